// ----- sv/ipv4_prefix_block_table_core_assert.svh -----
// ----------------------------------------------------------------------------
// ipv4_prefix_block_table_core assertion macros
// Clocked, reset-qualified property wrappers for the prefix table checks.
// ----------------------------------------------------------------------------
`ifndef IPV4_PREFIX_BLOCK_TABLE_CORE_ASSERT_SVH
`define IPV4_PREFIX_BLOCK_TABLE_CORE_ASSERT_SVH

// Same-cycle implication
`define IPBT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define IPBT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/ipbt_pkg.sv -----
// ----------------------------------------------------------------------------
// ipbt_pkg
// Shared types, codes and helpers for the IPv4 prefix block table.
// ----------------------------------------------------------------------------
`default_nettype none

package ipbt_pkg;

    // Operation codes; code 3 is unused and does nothing
    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_ADD    = 2'd1,
        OP_REMOVE = 2'd2
    } t_op;

    // Result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    // Prefix length of an exact address
    localparam logic [5:0] LEN_EXACT = 6'd32;

    // Command held stable for the whole pass down the chain
    typedef struct packed {
        t_op         op;
        logic [31:0] addr;
        logic [31:0] net;   // address normalised by the clamped length
        logic [5:0]  len;   // clamped length
    } t_cmd;

    // Token handed from cell to cell
    typedef struct packed {
        logic active;
        logic hit;      // lookup matched
        logic present;  // identical entry already held
        logic claimed;  // free slot taken by this add
        logic found;    // exact entry removed
    } t_tok;

    // End-of-pass broadcast to all cells
    typedef struct packed {
        logic commit;   // pass finished: drop tentative marks
        logic cancel;   // duplicate seen: undo the tentative write
    } t_ctrl;

    // Mask of a prefix: ones in the top len bits
    function automatic logic [31:0] length_mask(input logic [5:0] len);
        logic [5:0] sh;
        sh = LEN_EXACT - len;
        if (len == 6'd0) begin
            length_mask = 32'h0;
        end else if (len >= LEN_EXACT) begin
            length_mask = 32'hFFFF_FFFF;
        end else begin
            length_mask = 32'hFFFF_FFFF << sh[4:0];
        end
    endfunction

endpackage

`default_nettype wire

// ----- sv/ipbt_cell.sv -----
// ----------------------------------------------------------------------------
// ipbt_cell
// One table slot: holds a prefix and processes the command token as it passes.
// ----------------------------------------------------------------------------
`default_nettype none

module ipbt_cell
    import ipbt_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_cmd  i_cmd,
    input  wire t_ctrl i_ctrl,
    input  wire t_tok  i_tok,
    output t_tok       o_tok
);

    logic [31:0] r_net;
    logic [5:0]  r_len;
    logic        r_valid;
    logic        r_pending;
    t_tok        r_tok;

    logic        n_valid;
    logic        n_pending;
    t_tok        n_tok;
    logic        w_write;

    // Slot behaviour while the token sits at this cell
    always_comb begin
        n_tok     = i_tok;
        n_valid   = r_valid;
        n_pending = r_pending;
        w_write   = 1'b0;
        if (i_tok.active) begin
            unique case (i_cmd.op)
                OP_LOOKUP: begin
                    if (r_valid && ((i_cmd.addr & length_mask(r_len)) == r_net)) begin
                        n_tok.hit = 1'b1;
                    end
                end
                OP_ADD: begin
                    if (r_valid) begin
                        if (r_net == i_cmd.net && r_len == i_cmd.len) begin
                            n_tok.present = 1'b1;
                        end
                    end else if (!i_tok.claimed) begin
                        // lowest free slot: write now, undone later on a duplicate
                        w_write       = 1'b1;
                        n_valid       = 1'b1;
                        n_pending     = 1'b1;
                        n_tok.claimed = 1'b1;
                    end
                end
                OP_REMOVE: begin
                    if (r_valid && r_len == LEN_EXACT && r_net == i_cmd.addr) begin
                        n_valid     = 1'b0;
                        n_tok.found = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
        // end of pass
        if (i_ctrl.commit) begin
            n_pending = 1'b0;
            if (i_ctrl.cancel && r_pending) begin
                n_valid = 1'b0;
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_pending <= 1'b0;
            r_tok     <= '0;
        end else begin
            r_valid   <= n_valid;
            r_pending <= n_pending;
            r_tok     <= n_tok;
        end
    end

    // Slot payload
    always_ff @(posedge i_clk) begin
        if (w_write) begin
            r_net <= i_cmd.net;
            r_len <= i_cmd.len;
        end
    end

    assign o_tok = r_tok;

endmodule

`default_nettype wire

// ----- sv/ipv4_prefix_block_table_core.sv -----
// ----------------------------------------------------------------------------
// ipv4_prefix_block_table_core
// Table of blocked IPv4 prefixes with lookup, add and exact remove.
// ----------------------------------------------------------------------------
//  Channel   | Handshake            | Signals
//  ----------+----------------------+-------------------------------------------
//  command   | start & !busy        | i_operation, i_address, i_prefix_length
//  result    | o_valid (one cycle)  | o_blocked, o_status
//
//  A command token walks a row of TABLE_ENTRIES cells, one cell per cycle;
//  from accept to result it passes the injection register, each cell and the
//  result register, and the next start is taken in the cycle the result is shown.
//  busy stays high from accept until the result is registered.
//  Reset clears all valid bits at once; no clearing pass is needed.
//  The receiver cannot stall: each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4_prefix_block_table_core
    import ipbt_pkg::*;
#(
    parameter int TABLE_ENTRIES = 64
)
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_operation,
    input  wire logic [31:0] i_address,
    input  wire logic [5:0]  i_prefix_length,
    output logic             o_valid,
    output logic             o_blocked,
    output logic [1:0]       o_status
);

`include "ipv4_prefix_block_table_core_assert.svh"

    logic        r_busy;
    t_cmd        r_cmd;
    t_tok        r_inj;
    logic        r_valid;
    logic        r_blocked;
    logic [1:0]  r_status;

    logic        w_accept;
    logic [5:0]  w_len;
    t_tok        w_tok [TABLE_ENTRIES+1];
    t_tok        w_last;
    t_ctrl       w_ctrl;
    logic        n_blocked;
    logic [1:0]  n_status;

    assign w_accept = start && !r_busy;
    assign w_len    = (i_prefix_length > LEN_EXACT) ? LEN_EXACT : i_prefix_length;

    // Command capture and token injection
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_inj  <= '0;
        end else begin
            r_inj <= '0;
            if (w_accept) begin
                r_busy       <= 1'b1;
                r_inj.active <= 1'b1;
            end else if (w_last.active) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd.op   <= t_op'(i_operation);
            r_cmd.addr <= i_address;
            r_cmd.net  <= i_address & length_mask(w_len);
            r_cmd.len  <= w_len;
        end
    end

    // Row of cells
    assign w_tok[0] = r_inj;

    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        ipbt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (r_cmd),
            .i_ctrl  (w_ctrl),
            .i_tok   (w_tok[g]),
            .o_tok   (w_tok[g+1])
        );
    end

    assign w_last = w_tok[TABLE_ENTRIES];

    // End of pass: settle tentative add
    always_comb begin
        w_ctrl.commit = w_last.active;
        w_ctrl.cancel = w_last.active && w_last.present;
    end

    // Result from the token leaving the row
    always_comb begin
        n_blocked = 1'b0;
        n_status  = ST_OK;
        unique case (r_cmd.op)
            OP_LOOKUP: n_blocked = w_last.hit;
            OP_ADD: begin
                if (!w_last.present && !w_last.claimed) begin
                    n_status = ST_FULL;
                end
            end
            OP_REMOVE: begin
                if (!w_last.found) begin
                    n_status = ST_NOT_FOUND;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_last.active;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_last.active) begin
            r_blocked <= n_blocked;
            r_status  <= n_status;
        end
    end

    assign busy      = r_busy;
    assign o_valid   = r_valid;
    assign o_blocked = r_blocked;
    assign o_status  = r_status;

    // Checks
    `IPBT_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "busy not raised after accept")
    `IPBT_ASSERT_NOW(a_result_idle, o_valid, !busy, "result shown while still busy")
    `IPBT_ASSERT_NEXT(a_single_result, o_valid, !o_valid, "result repeated")
    `IPBT_ASSERT_NOW(a_blocked_ok, o_valid && o_blocked, o_status == ST_OK,
        "blocked reported with an error status")

endmodule

`default_nettype wire
